### hdl/ucbsel_pkg.sv
// Shared constants, codes and types for the UCB1 arm selector.
`default_nettype none
package ucbsel_pkg;

  localparam int MAX_ARMS       = 64;
  localparam int ARM_W          = $clog2(MAX_ARMS);
  localparam int CNT_W          = ARM_W + 1;
  localparam int MEAN_FRAC_BITS = 16;
  localparam int CTR_W          = 32;
  localparam int LN_FRAC        = 16;
  localparam int LOG_INT_W      = 5;
  localparam int SQ_CNT_W       = $clog2(LN_FRAC);
  localparam int RAD_TARGET     = 2 * MEAN_FRAC_BITS;
  localparam int RAD_SHL        = (RAD_TARGET >= 28) ? (RAD_TARGET - 28) : 0;
  localparam int RAD_SHR        = (RAD_TARGET >= 28) ? 0 : (28 - RAD_TARGET);
  localparam int DIV_W          = CTR_W + MEAN_FRAC_BITS;
  localparam int SQRT_W         = DIV_W / 2;
  localparam int STEP_W         = $clog2(DIV_W);
  localparam int SCORE_W        = DIV_W + 1;
  localparam int MUL_W          = 32;

  localparam logic [MUL_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam logic [CTR_W-1:0] SAT_MAX = '1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARM_COUNT     = 2'd0,
    CFG_EXPLORE_RATIO = 2'd1,
    CFG_PLAY_BUDGET   = 2'd2,
    CFG_BUDGET_MODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_DECIDE,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_LN_MUL,
    ST_C_MUL,
    ST_BASE,
    ST_ARM_RD,
    ST_ARM_LD,
    ST_MEAN_DIV,
    ST_BONUS_DIV,
    ST_SQRT,
    ST_ARM_CMP,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

### hdl/ucb1_bandit_arm_selector_unit.sv
// UCB1 bandit arm selector: arm table, sequencer, shared multiplier and divider, and a square-root unit.
// UCB pick: ln(total) on the shared multiplier (normalised to the leading one),
//   then per played arm two 48-step divisions and a 24-step root; unplayed arms skip them.
// Stop / budget end: mean division only per played arm; one item in flight at a time.
// Reset clears all control state and the per-arm valid bits (table reads zero).
`default_nettype none
module ucb1_bandit_arm_selector_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid_i,
  output      logic                                  s_axis_tready_o,
  // [1:0] action, [2] won, rest zero
  input  wire logic [ucbsel_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output      logic                                  m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // [5:0] arm_to_play, [11:6] best_arm, [12] best_found, [44:13] total_plays
  output      logic [ucbsel_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // search_done
  output      logic                                  m_axis_tlast_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ucbsel_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [ucbsel_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int AW  = ucbsel_pkg::ARM_W;
  localparam int CW  = ucbsel_pkg::CTR_W;
  localparam int DW  = ucbsel_pkg::DIV_W;
  localparam int SW  = ucbsel_pkg::SQRT_W;
  localparam int NW  = ucbsel_pkg::CNT_W;
  localparam int MW  = ucbsel_pkg::MUL_W;
  localparam int FB  = ucbsel_pkg::MEAN_FRAC_BITS;
  localparam int LF  = ucbsel_pkg::LN_FRAC;
  localparam int LIW = ucbsel_pkg::LOG_INT_W;
  localparam int PW  = ucbsel_pkg::SCORE_W;
  localparam int TW  = ucbsel_pkg::STEP_W;
  localparam int SQ_CNT_W_L = ucbsel_pkg::SQ_CNT_W;

  ucbsel_pkg::state_e state_q, state_d;

  // configuration
  logic [NW-1:0] arm_count_q;
  logic [15:0]   explore_q;
  logic [CW-1:0] budget_q;
  logic          mode_q;

  // control state
  logic [ucbsel_pkg::MAX_ARMS-1:0] valid_q;
  logic [CW-1:0] total_q;
  logic [AW-1:0] issued_q;
  logic [NW-1:0] sweep_q;
  logic          active_q;
  logic          m_tvalid_q;

  // payload and datapath
  logic [2*CW-1:0] mem_q [ucbsel_pkg::MAX_ARMS];
  logic [2*CW-1:0] rd_q;
  logic            rd_vld_q;
  logic            won_q;
  logic            fin_q;
  logic [2*MW-1:0] mul_q;
  logic [MW-1:0]   y_q;
  logic [LIW-1:0]  k_q;
  logic [LF-1:0]   frac_q;
  logic [SQ_CNT_W_L-1:0] sq_cnt_q;
  logic [DW-1:0]   base_q;
  logic [DW-1:0]   quo_q;
  logic [CW-1:0]   rem_q;
  logic [CW-1:0]   dvs_q;
  logic [TW-1:0]   step_q;
  logic [DW-1:0]   rad_q;
  logic [SW+1:0]   srem_q;
  logic [SW-1:0]   root_q;
  logic [DW-1:0]   mean_q;
  logic [PW-1:0]   score_q;
  logic [PW-1:0]   best_q;
  logic [AW-1:0]   pick_q;
  logic            found_q;
  logic [AW-1:0]   arm_idx_q;
  logic [AW-1:0]   res_arm_q;
  logic            res_done_q;
  logic [AW-1:0]   res_best_q;
  logic            res_found_q;
  logic [ucbsel_pkg::OUT_TDATA_W-1:0] m_tdata_q;
  logic            m_tlast_q;

  // derived values
  logic [NW-1:0]   n_arms;
  logic [AW-1:0]   last_arm;
  logic            accept;
  logic            out_free;
  logic [CW-1:0]   rd_wins, rd_plays;
  logic [CW-1:0]   new_wins, new_plays, new_total;
  logic [MW-1:0]   mul_a, mul_b;
  logic [CW:0]     div_trial;
  logic            div_ge;
  logic [SW+3:0]   sq_tmp, sq_trial;
  logic            sq_ge;
  logic            div_last, sq_last;

  always_comb begin
    if (arm_count_q == '0) begin
      n_arms = NW'(1);
    end else if (arm_count_q > NW'(ucbsel_pkg::MAX_ARMS)) begin
      n_arms = NW'(ucbsel_pkg::MAX_ARMS);
    end else begin
      n_arms = arm_count_q;
    end
  end
  assign last_arm = AW'(n_arms - NW'(1));

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_tvalid_q || m_axis_tready_i;

  assign rd_wins   = rd_vld_q ? rd_q[2*CW-1:CW] : '0;
  assign rd_plays  = rd_vld_q ? rd_q[CW-1:0] : '0;
  assign new_plays = (rd_plays == ucbsel_pkg::SAT_MAX) ? rd_plays : rd_plays + CW'(1);
  assign new_wins  = (won_q && rd_wins != ucbsel_pkg::SAT_MAX) ? rd_wins + CW'(1) : rd_wins;
  assign new_total = (total_q == ucbsel_pkg::SAT_MAX) ? total_q : total_q + CW'(1);

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ucbsel_pkg::ST_LN_MUL: begin
        mul_a = MW'({k_q, frac_q});
        mul_b = ucbsel_pkg::LN2_Q32;
      end
      ucbsel_pkg::ST_C_MUL: begin
        mul_a = mul_q[2*MW-1:MW];
        mul_b = MW'(explore_q);
      end
      default: begin
        mul_a = y_q;
        mul_b = y_q;
      end
    endcase
  end

  // restoring divider step
  assign div_trial = {rem_q, quo_q[DW-1]};
  assign div_ge    = div_trial >= {1'b0, dvs_q};
  assign div_last  = step_q == TW'(DW - 1);

  // digit-by-digit square root step
  assign sq_tmp   = {srem_q, rad_q[DW-1:DW-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_tmp >= sq_trial;
  assign sq_last  = step_q == TW'(SW - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ucbsel_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_axis_tdata_i[1:0])
            ucbsel_pkg::ACT_START:  state_d = ucbsel_pkg::ST_OUT;
            ucbsel_pkg::ACT_STOP:   state_d = ucbsel_pkg::ST_ARM_RD;
            ucbsel_pkg::ACT_REPORT: state_d = active_q ? ucbsel_pkg::ST_UPD_RD
                                                       : ucbsel_pkg::ST_OUT;
            default:                state_d = ucbsel_pkg::ST_OUT;
          endcase
        end
      end
      ucbsel_pkg::ST_UPD_RD: state_d = ucbsel_pkg::ST_UPD_WR;
      ucbsel_pkg::ST_UPD_WR: state_d = ucbsel_pkg::ST_DECIDE;
      ucbsel_pkg::ST_DECIDE: begin
        if (sweep_q < n_arms) begin
          state_d = ucbsel_pkg::ST_OUT;
        end else if (mode_q && total_q >= budget_q) begin
          state_d = ucbsel_pkg::ST_ARM_RD;
        end else begin
          state_d = ucbsel_pkg::ST_NORM;
        end
      end
      ucbsel_pkg::ST_NORM:   if (y_q[MW-1] || y_q == '0) state_d = ucbsel_pkg::ST_SQ_MUL;
      ucbsel_pkg::ST_SQ_MUL: state_d = ucbsel_pkg::ST_SQ_ACC;
      ucbsel_pkg::ST_SQ_ACC: begin
        state_d = (sq_cnt_q == SQ_CNT_W_L'(LF - 1)) ? ucbsel_pkg::ST_LN_MUL
                                                    : ucbsel_pkg::ST_SQ_MUL;
      end
      ucbsel_pkg::ST_LN_MUL: state_d = ucbsel_pkg::ST_C_MUL;
      ucbsel_pkg::ST_C_MUL:  state_d = ucbsel_pkg::ST_BASE;
      ucbsel_pkg::ST_BASE:   state_d = ucbsel_pkg::ST_ARM_RD;
      ucbsel_pkg::ST_ARM_RD: state_d = ucbsel_pkg::ST_ARM_LD;
      ucbsel_pkg::ST_ARM_LD: begin
        state_d = (rd_plays == '0) ? ucbsel_pkg::ST_ARM_CMP : ucbsel_pkg::ST_MEAN_DIV;
      end
      ucbsel_pkg::ST_MEAN_DIV: begin
        if (div_last) state_d = fin_q ? ucbsel_pkg::ST_ARM_CMP : ucbsel_pkg::ST_BONUS_DIV;
      end
      ucbsel_pkg::ST_BONUS_DIV: if (div_last) state_d = ucbsel_pkg::ST_SQRT;
      ucbsel_pkg::ST_SQRT:      if (sq_last) state_d = ucbsel_pkg::ST_ARM_CMP;
      ucbsel_pkg::ST_ARM_CMP: begin
        state_d = (arm_idx_q == last_arm) ? ucbsel_pkg::ST_OUT : ucbsel_pkg::ST_ARM_RD;
      end
      ucbsel_pkg::ST_OUT: if (out_free) state_d = ucbsel_pkg::ST_IDLE;
      default: state_d = ucbsel_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ucbsel_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_count_q <= NW'(1);
      explore_q   <= 16'd6144;
      budget_q    <= CW'(1000);
      mode_q      <= 1'b0;
      valid_q     <= '0;
      total_q     <= '0;
      issued_q    <= '0;
      sweep_q     <= '0;
      active_q    <= 1'b0;
      m_tvalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ucbsel_pkg::CFG_ARM_COUNT:     arm_count_q <= cfg_wdata_i[NW-1:0];
          ucbsel_pkg::CFG_EXPLORE_RATIO: explore_q   <= cfg_wdata_i[15:0];
          ucbsel_pkg::CFG_PLAY_BUDGET:   budget_q    <= cfg_wdata_i[CW-1:0];
          ucbsel_pkg::CFG_BUDGET_MODE:   mode_q      <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (state_q == ucbsel_pkg::ST_OUT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ucbsel_pkg::ST_IDLE: begin
          if (accept) begin
            case (s_axis_tdata_i[1:0])
              ucbsel_pkg::ACT_START: begin
                valid_q  <= '0;
                total_q  <= '0;
                issued_q <= '0;
                sweep_q  <= NW'(1);
                active_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ucbsel_pkg::ST_UPD_WR: begin
          valid_q[issued_q] <= 1'b1;
          total_q           <= new_total;
        end
        ucbsel_pkg::ST_DECIDE: begin
          if (sweep_q < n_arms) begin
            issued_q <= AW'(sweep_q);
            sweep_q  <= sweep_q + NW'(1);
          end
        end
        ucbsel_pkg::ST_ARM_CMP: begin
          if (arm_idx_q == last_arm) begin
            if (fin_q) begin
              active_q <= 1'b0;
            end else if (score_q > best_q) begin
              issued_q <= arm_idx_q;
            end else begin
              issued_q <= pick_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // arm table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == ucbsel_pkg::ST_UPD_WR) begin
      mem_q[issued_q] <= {new_wins, new_plays};
    end
    if (state_q == ucbsel_pkg::ST_UPD_RD) begin
      rd_q     <= mem_q[issued_q];
      rd_vld_q <= valid_q[issued_q];
    end else begin
      rd_q     <= mem_q[arm_idx_q];
      rd_vld_q <= valid_q[arm_idx_q];
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ucbsel_pkg::ST_IDLE: begin
        won_q     <= s_axis_tdata_i[2];
        fin_q     <= 1'b1;
        arm_idx_q <= '0;
        best_q    <= '0;
        pick_q    <= '0;
        found_q   <= 1'b0;
        res_arm_q   <= '0;
        res_best_q  <= '0;
        res_found_q <= 1'b0;
        res_done_q  <= 1'b0;
      end
      ucbsel_pkg::ST_DECIDE: begin
        res_arm_q <= AW'(sweep_q);
        fin_q     <= !(sweep_q < n_arms) && mode_q && total_q >= budget_q;
        y_q       <= total_q;
        k_q       <= LIW'(MW - 1);
        frac_q    <= '0;
        sq_cnt_q  <= '0;
      end
      ucbsel_pkg::ST_NORM: begin
        if (!y_q[MW-1] && y_q != '0) begin
          y_q <= {y_q[MW-2:0], 1'b0};
          k_q <= k_q - LIW'(1);
        end
      end
      ucbsel_pkg::ST_SQ_MUL, ucbsel_pkg::ST_LN_MUL, ucbsel_pkg::ST_C_MUL: begin
        mul_q <= mul_a * mul_b;
      end
      ucbsel_pkg::ST_SQ_ACC: begin
        // keep Q1.31; an overflow above two yields a one bit
        if (mul_q[2*MW-1]) begin
          y_q    <= mul_q[2*MW-1:MW];
          frac_q <= {frac_q[LF-2:0], 1'b1};
        end else begin
          y_q    <= mul_q[2*MW-2:MW-1];
          frac_q <= {frac_q[LF-2:0], 1'b0};
        end
        sq_cnt_q <= sq_cnt_q + SQ_CNT_W_L'(1);
      end
      ucbsel_pkg::ST_BASE: begin
        base_q <= DW'((mul_q << ucbsel_pkg::RAD_SHL) >> ucbsel_pkg::RAD_SHR);
      end
      ucbsel_pkg::ST_ARM_LD: begin
        quo_q  <= {rd_wins, FB'(0)};
        dvs_q  <= rd_plays;
        rem_q  <= '0;
        step_q <= '0;
        score_q <= fin_q ? '0 : '1;
      end
      ucbsel_pkg::ST_MEAN_DIV, ucbsel_pkg::ST_BONUS_DIV: begin
        rem_q  <= div_ge ? CW'(div_trial - {1'b0, dvs_q}) : CW'(div_trial);
        quo_q  <= {quo_q[DW-2:0], div_ge};
        step_q <= div_last ? '0 : step_q + TW'(1);
        if (div_last) begin
          if (state_q == ucbsel_pkg::ST_MEAN_DIV) begin
            mean_q  <= {quo_q[DW-2:0], div_ge};
            score_q <= PW'({quo_q[DW-2:0], div_ge});
            quo_q   <= base_q;
            rem_q   <= '0;
          end else begin
            rad_q  <= {quo_q[DW-2:0], div_ge};
            srem_q <= '0;
            root_q <= '0;
          end
        end
      end
      ucbsel_pkg::ST_SQRT: begin
        srem_q <= sq_ge ? (SW+2)'(sq_tmp - sq_trial) : (SW+2)'(sq_tmp);
        root_q <= {root_q[SW-2:0], sq_ge};
        rad_q  <= {rad_q[DW-3:0], 2'b00};
        step_q <= sq_last ? '0 : step_q + TW'(1);
        if (sq_last) score_q <= PW'(mean_q) + PW'({root_q[SW-2:0], sq_ge});
      end
      ucbsel_pkg::ST_ARM_CMP: begin
        if (score_q > best_q) begin
          best_q  <= score_q;
          pick_q  <= arm_idx_q;
          found_q <= 1'b1;
        end
        arm_idx_q <= arm_idx_q + AW'(1);
        if (arm_idx_q == last_arm) begin
          if (fin_q) begin
            res_arm_q   <= '0;
            res_done_q  <= 1'b1;
            res_found_q <= found_q || (score_q > best_q);
            res_best_q  <= (score_q > best_q) ? arm_idx_q : (found_q ? pick_q : '0);
          end else begin
            res_arm_q   <= (score_q > best_q) ? arm_idx_q : pick_q;
          end
        end
      end
      ucbsel_pkg::ST_OUT: begin
        if (out_free) begin
          m_tdata_q <= ucbsel_pkg::OUT_TDATA_W'({total_q, res_found_q, res_best_q, res_arm_q});
          m_tlast_q <= res_done_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = state_q == ucbsel_pkg::ST_IDLE;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tlast_o  = m_tlast_q;

  // a finished search never names an arm to play
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[AW-1:0] == '0)
    else $error("arm_to_play set on a finished search");

  // no best arm without a mean above zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[2*AW] |-> m_axis_tdata_o[2*AW-1:AW] == '0)
    else $error("best_arm set without best_found");

  // every transfer in leaves idle, so ready is low in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("ready held across an accepted item");

  // start clears the play total and arms the search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tdata_i[1:0] == ucbsel_pkg::ACT_START |=> total_q == '0 && active_q)
    else $error("start did not reset the search");

  // sweep index at most MAX_ARMS plus one, or above the arm count, while searching
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> sweep_q <= NW'(ucbsel_pkg::MAX_ARMS) + NW'(1) || sweep_q > n_arms)
    else $error("sweep index out of range");

endmodule
`default_nettype wire
